>>> src/hrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, character constants and byte classes for the request head parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

   typedef enum logic [4:0] {
      PH_METHOD_FIRST = 5'd0,
      PH_METHOD       = 5'd1,
      PH_URI_FIRST    = 5'd2,
      PH_URI          = 5'd3,
      PH_H            = 5'd4,
      PH_T1           = 5'd5,
      PH_T2           = 5'd6,
      PH_P            = 5'd7,
      PH_SLASH        = 5'd8,
      PH_MAJOR_FIRST  = 5'd9,
      PH_MAJOR        = 5'd10,
      PH_MINOR_FIRST  = 5'd11,
      PH_MINOR        = 5'd12,
      PH_LINE_LF      = 5'd13,
      PH_HDR_FIRST    = 5'd14,
      PH_HDR_NAME     = 5'd15,
      PH_HDR_SP       = 5'd16,
      PH_HDR_VALUE    = 5'd17,
      PH_HDR_LF       = 5'd18,
      PH_END_LF       = 5'd19
   } phase_type;

   typedef enum logic [2:0] {
      KIND_DELIM  = 3'd0,
      KIND_METHOD = 3'd1,
      KIND_URI    = 3'd2,
      KIND_NAME   = 3'd3,
      KIND_VALUE  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ERR  = 2'd1,
      ST_DONE = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   field_kind;
      logic       field_first;
      logic       pair_end;
      logic       version_ready;
      logic [7:0] version_major;
      logic [7:0] version_minor;
      status_type status;
   } result_type;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DEL   = 8'd127;
   localparam logic [7:0] CH_CTL   = 8'd31;
   localparam logic [7:0] CH_VIS_LO = 8'd33;
   localparam logic [7:0] CH_VIS_HI = 8'd126;
   localparam logic [7:0] ACC_MAX  = 8'd255;

   function automatic logic is_visible(input logic [7:0] c);
      return (c >= CH_VIS_LO) && (c <= CH_VIS_HI);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      logic s;
      case (c)
         8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
         8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
         8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
         8'h7B, 8'h7D, 8'h20, 8'h09: s = 1'b1;
         default: s = 1'b0;
      endcase
      return s;
   endfunction

   function automatic logic is_token(input logic [7:0] c);
      return is_visible(c) && !is_sep(c);
   endfunction

   function automatic logic is_value_byte(input logic [7:0] c);
      return (c > CH_CTL) && (c != CH_DEL);
   endfunction

   function automatic logic is_num(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // acc * 10 + digit, clipped to 255
   function automatic logic [7:0] sat_acc(input logic [7:0] acc, input logic [7:0] c);
      logic [11:0] v;
      v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, c[3:0]};
      return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[7:0];
   endfunction

endpackage
`default_nettype wire

>>> src/hrp_input_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_input_reg
// Input byte register; frees itself in the same cycle it is drained.
// ----------------------------------------------------------------------------
module hrp_input_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   output logic            in_ready,
   output logic            out_valid,
   output logic [7:0]      out_byte,
   input  wire logic       out_take
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
   end

endmodule
`default_nettype wire

>>> src/hrp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_parser
// Parse state machine: classifies one byte and advances the phase.
// ----------------------------------------------------------------------------
module hrp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [7:0]        byte_in,
   output hrp_pkg::result_type    result
);

   hrp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         major_ff, major_in;
   logic [7:0]         minor_ff, minor_in;
   logic               seen_ff, seen_in;
   logic               byte_ok;

   // next state
   always_comb begin
      phase_in = phase_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      seen_in  = seen_ff;
      byte_ok  = 1'b1;
      case (phase_ff)
         hrp_pkg::PH_METHOD_FIRST: begin
            if (hrp_pkg::is_token(byte_in)) phase_in = hrp_pkg::PH_METHOD;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_METHOD: begin
            if (byte_in == hrp_pkg::CH_SP) phase_in = hrp_pkg::PH_URI_FIRST;
            else if (!hrp_pkg::is_token(byte_in)) byte_ok = 1'b0;
         end
         hrp_pkg::PH_URI_FIRST: begin
            if (hrp_pkg::is_visible(byte_in)) phase_in = hrp_pkg::PH_URI;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_URI: begin
            if (byte_in == hrp_pkg::CH_SP) phase_in = hrp_pkg::PH_H;
            else if (!hrp_pkg::is_visible(byte_in)) byte_ok = 1'b0;
         end
         hrp_pkg::PH_H: begin
            if (byte_in == hrp_pkg::CH_H) phase_in = hrp_pkg::PH_T1;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_T1: begin
            if (byte_in == hrp_pkg::CH_T) phase_in = hrp_pkg::PH_T2;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_T2: begin
            if (byte_in == hrp_pkg::CH_T) phase_in = hrp_pkg::PH_P;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_P: begin
            if (byte_in == hrp_pkg::CH_P) phase_in = hrp_pkg::PH_SLASH;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_SLASH: begin
            if (byte_in == hrp_pkg::CH_SLASH) phase_in = hrp_pkg::PH_MAJOR_FIRST;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_MAJOR_FIRST: begin
            if (hrp_pkg::is_num(byte_in)) begin
               major_in = {4'd0, byte_in[3:0]};
               phase_in = hrp_pkg::PH_MAJOR;
            end else begin
               byte_ok = 1'b0;
            end
         end
         hrp_pkg::PH_MAJOR: begin
            if (byte_in == hrp_pkg::CH_DOT) phase_in = hrp_pkg::PH_MINOR_FIRST;
            else if (hrp_pkg::is_num(byte_in)) major_in = hrp_pkg::sat_acc(major_ff, byte_in);
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_MINOR_FIRST: begin
            if (hrp_pkg::is_num(byte_in)) begin
               minor_in = {4'd0, byte_in[3:0]};
               phase_in = hrp_pkg::PH_MINOR;
            end else begin
               byte_ok = 1'b0;
            end
         end
         hrp_pkg::PH_MINOR: begin
            if (hrp_pkg::is_num(byte_in)) minor_in = hrp_pkg::sat_acc(minor_ff, byte_in);
            else if (byte_in == hrp_pkg::CH_CR) phase_in = hrp_pkg::PH_LINE_LF;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_LINE_LF, hrp_pkg::PH_HDR_LF: begin
            if (byte_in == hrp_pkg::CH_LF) phase_in = hrp_pkg::PH_HDR_FIRST;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_HDR_FIRST: begin
            if (byte_in == hrp_pkg::CH_CR) phase_in = hrp_pkg::PH_END_LF;
            else if (hrp_pkg::is_token(byte_in)) phase_in = hrp_pkg::PH_HDR_NAME;
            else byte_ok = 1'b0;
         end
         hrp_pkg::PH_HDR_NAME: begin
            if (byte_in == hrp_pkg::CH_COLON) phase_in = hrp_pkg::PH_HDR_SP;
            else if (!hrp_pkg::is_token(byte_in)) byte_ok = 1'b0;
         end
         hrp_pkg::PH_HDR_SP: begin
            if (byte_in == hrp_pkg::CH_SP) begin
               seen_in  = 1'b0;
               phase_in = hrp_pkg::PH_HDR_VALUE;
            end else begin
               byte_ok = 1'b0;
            end
         end
         hrp_pkg::PH_HDR_VALUE: begin
            if (byte_in == hrp_pkg::CH_CR) begin
               if (seen_ff) begin
                  seen_in  = 1'b0;
                  phase_in = hrp_pkg::PH_HDR_LF;
               end else begin
                  byte_ok = 1'b0;
               end
            end else if (hrp_pkg::is_value_byte(byte_in)) begin
               seen_in = 1'b1;
            end else begin
               byte_ok = 1'b0;
            end
         end
         hrp_pkg::PH_END_LF: begin
            if (byte_in == hrp_pkg::CH_LF) begin
               phase_in = hrp_pkg::PH_METHOD_FIRST;
               major_in = 8'd0;
               minor_in = 8'd0;
               seen_in  = 1'b0;
            end else begin
               byte_ok = 1'b0;
            end
         end
         default: begin
            byte_ok = 1'b0;
         end
      endcase
   end

   // outputs
   always_comb begin
      result               = '0;
      result.out_byte      = byte_in;
      result.field_kind    = hrp_pkg::KIND_DELIM;
      result.status        = hrp_pkg::ST_OK;
      case (phase_ff)
         hrp_pkg::PH_METHOD_FIRST: begin
            result.field_kind  = hrp_pkg::KIND_METHOD;
            result.field_first = 1'b1;
         end
         hrp_pkg::PH_METHOD: begin
            if (byte_in != hrp_pkg::CH_SP) result.field_kind = hrp_pkg::KIND_METHOD;
         end
         hrp_pkg::PH_URI_FIRST: begin
            result.field_kind  = hrp_pkg::KIND_URI;
            result.field_first = 1'b1;
         end
         hrp_pkg::PH_URI: begin
            if (byte_in != hrp_pkg::CH_SP) result.field_kind = hrp_pkg::KIND_URI;
         end
         hrp_pkg::PH_MINOR: begin
            if (byte_in == hrp_pkg::CH_CR) begin
               result.version_ready = 1'b1;
               result.version_major = major_ff;
               result.version_minor = minor_ff;
            end
         end
         hrp_pkg::PH_HDR_FIRST: begin
            if (byte_in != hrp_pkg::CH_CR) begin
               result.field_kind  = hrp_pkg::KIND_NAME;
               result.field_first = 1'b1;
            end
         end
         hrp_pkg::PH_HDR_NAME: begin
            if (byte_in != hrp_pkg::CH_COLON) result.field_kind = hrp_pkg::KIND_NAME;
         end
         hrp_pkg::PH_HDR_VALUE: begin
            if (byte_in == hrp_pkg::CH_CR) begin
               result.pair_end = 1'b1;
            end else begin
               result.field_kind  = hrp_pkg::KIND_VALUE;
               result.field_first = !seen_ff;
            end
         end
         hrp_pkg::PH_END_LF: begin
            result.status = hrp_pkg::ST_DONE;
         end
         default: begin
            result.status = hrp_pkg::ST_OK;
         end
      endcase
      if (!byte_ok) begin
         result               = '0;
         result.out_byte      = byte_in;
         result.field_kind    = hrp_pkg::KIND_DELIM;
         result.status        = hrp_pkg::ST_ERR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrp_pkg::PH_METHOD_FIRST;
         major_ff <= 8'd0;
         minor_ff <= 8'd0;
         seen_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
         seen_ff  <= seen_in;
      end
   end

   a_err_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && result.status == hrp_pkg::ST_ERR |=>
      phase_ff == $past(phase_ff) && major_ff == $past(major_ff) &&
      minor_ff == $past(minor_ff) && seen_ff == $past(seen_ff))
      else $error("rejected byte changed parser state");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && result.status == hrp_pkg::ST_DONE |=>
      phase_ff == hrp_pkg::PH_METHOD_FIRST && major_ff == 8'd0 &&
      minor_ff == 8'd0 && !seen_ff)
      else $error("head completion did not restart parser");

   a_vready_phase: assert property (@(posedge clock) disable iff (reset)
      step_en && result.version_ready |=> phase_ff == hrp_pkg::PH_LINE_LF)
      else $error("version report without request line end");

   a_pair_end: assert property (@(posedge clock) disable iff (reset)
      step_en && result.pair_end |-> $past(seen_ff) || seen_ff)
      else $error("header pair closed with empty value");

   a_first_kind: assert property (@(posedge clock) disable iff (reset)
      result.field_first |-> result.field_kind != hrp_pkg::KIND_DELIM)
      else $error("field start flagged on delimiter");

endmodule
`default_nettype wire

>>> src/hrp_output_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_output_reg
// Result register holding one tagged byte until the receiver takes it.
// ----------------------------------------------------------------------------
module hrp_output_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire hrp_pkg::result_type in_result,
   output logic                     in_ready,
   output logic                     out_valid,
   output hrp_pkg::result_type      out_result,
   input  wire logic                out_ready
);

   logic                valid_ff, valid_in;
   hrp_pkg::result_type result_ff;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= in_result;
      end
   end

endmodule
`default_nettype wire

>>> src/http_request_head_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_head_parser_top
// Byte-wide request head parser: tags each byte with its field and state.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one raw request byte per item on req_tdata[7:0].
//   rsp_*  : exactly one result item per input byte, in order. tuser carries
//            the field kind and field-start flag; tdata carries the echoed
//            byte, pair end, version ready, both versions and status.
//   Path: req accept loads the input register, then parse logic loads the
//            result register, which raises rsp_tvalid.
//   Throughput: one byte per cycle while rsp_tready is high; the parse phase
//            register updates as each byte moves from input to result register.
//   Reset: both registers empty, parser expects the first method byte,
//            version accumulators and value flag cleared.
//   Stall: with rsp_tready low the result register holds, the input register
//            fills, and req_tready drops until the result is taken.
//   A rejected byte reports status error and leaves the parse state as is;
//   the LF of the empty line reports status done and restarts the parser.
// ----------------------------------------------------------------------------
module http_request_head_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [7:0] out_byte, [8] pair_end,
                                         // [9] version_ready, [17:10] version_major,
                                         // [25:18] version_minor, [27:26] status
   output logic [7:0]       rsp_tuser    // [2:0] field_kind, [3] field_first
);

   logic                s1_valid;
   logic [7:0]          s1_byte;
   logic                out_ready_int;
   logic                step_en;
   hrp_pkg::result_type step_result;
   hrp_pkg::result_type rsp_result;

   assign step_en = s1_valid && out_ready_int;

   hrp_input_reg u_input_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_byte   (req_tdata),
      .in_ready  (req_tready),
      .out_valid (s1_valid),
      .out_byte  (s1_byte),
      .out_take  (step_en)
   );

   hrp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .byte_in (s1_byte),
      .result  (step_result)
   );

   hrp_output_reg u_output_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid),
      .in_result  (step_result),
      .in_ready   (out_ready_int),
      .out_valid  (rsp_tvalid),
      .out_result (rsp_result),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {4'd0,
                       rsp_result.status,
                       rsp_result.version_minor,
                       rsp_result.version_major,
                       rsp_result.version_ready,
                       rsp_result.pair_end,
                       rsp_result.out_byte};

   assign rsp_tuser = {4'd0, rsp_result.field_first, rsp_result.field_kind};

endmodule
`default_nettype wire

>>> test/http_request_head_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_head_parser_top_test
// Self-checking bench for the byte-wide request head parser. A queue of bytes
// is filled once: a short directed request that hits the error and saturation
// cases, then random requests with noise bytes and cut-off requests mixed in.
// Each accepted byte runs through a local parser model and the expected tags
// are compared in order with the result items, under random stalls on both
// sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module http_request_head_parser_top_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [7:0]  rsp_tuser;

   logic [7:0]          byte_stream[$];
   hrp_pkg::result_type expected_tags[$];
   int                  total_bytes;
   int                  offered_bytes;
   int                  accepted_bytes;
   int                  results_seen;
   int                  mismatches;
   int                  cycles;
   int                  hold_left;
   bit                  hold_done;

   // local parser state
   hrp_pkg::phase_type  parse_state;
   logic [7:0]          major_count;
   logic [7:0]          minor_count;
   logic                value_started;

   http_request_head_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic visible_char(input logic [7:0] c);
      return c >= 8'd33 && c <= 8'd126;
   endfunction

   function automatic logic token_char(input logic [7:0] c);
      logic delim;
      case (c)
         "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
         "/", "[", "]", "?", "=", "{", "}", " ", 8'h09: delim = 1'b1;
         default: delim = 1'b0;
      endcase
      return visible_char(c) && !delim;
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return c >= hrp_pkg::CH_ZERO && c <= hrp_pkg::CH_NINE;
   endfunction

   function automatic logic [7:0] decimal_push(input logic [7:0] acc, input logic [7:0] c);
      int v;
      v = int'(acc) * 10 + int'(c - hrp_pkg::CH_ZERO);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // tags one byte and advances the local parser state
   function automatic hrp_pkg::result_type tag_byte(input logic [7:0] c);
      hrp_pkg::result_type r;
      logic                ok;
      hrp_pkg::phase_type  nxt;
      r = '0;
      r.field_kind = hrp_pkg::KIND_DELIM;
      r.status = hrp_pkg::ST_OK;
      r.out_byte = c;
      ok = 1'b1;
      nxt = parse_state;
      case (parse_state)
         hrp_pkg::PH_METHOD_FIRST: begin
            if (token_char(c)) begin
               r.field_kind = hrp_pkg::KIND_METHOD; r.field_first = 1'b1;
               nxt = hrp_pkg::PH_METHOD;
            end else ok = 1'b0;
         end
         hrp_pkg::PH_METHOD: begin
            if (c == hrp_pkg::CH_SP) nxt = hrp_pkg::PH_URI_FIRST;
            else if (token_char(c)) r.field_kind = hrp_pkg::KIND_METHOD;
            else ok = 1'b0;
         end
         hrp_pkg::PH_URI_FIRST: begin
            if (visible_char(c)) begin
               r.field_kind = hrp_pkg::KIND_URI; r.field_first = 1'b1;
               nxt = hrp_pkg::PH_URI;
            end else ok = 1'b0;
         end
         hrp_pkg::PH_URI: begin
            if (c == hrp_pkg::CH_SP) nxt = hrp_pkg::PH_H;
            else if (visible_char(c)) r.field_kind = hrp_pkg::KIND_URI;
            else ok = 1'b0;
         end
         hrp_pkg::PH_H: begin
            if (c == hrp_pkg::CH_H) nxt = hrp_pkg::PH_T1; else ok = 1'b0;
         end
         hrp_pkg::PH_T1: begin
            if (c == hrp_pkg::CH_T) nxt = hrp_pkg::PH_T2; else ok = 1'b0;
         end
         hrp_pkg::PH_T2: begin
            if (c == hrp_pkg::CH_T) nxt = hrp_pkg::PH_P; else ok = 1'b0;
         end
         hrp_pkg::PH_P: begin
            if (c == hrp_pkg::CH_P) nxt = hrp_pkg::PH_SLASH; else ok = 1'b0;
         end
         hrp_pkg::PH_SLASH: begin
            if (c == hrp_pkg::CH_SLASH) nxt = hrp_pkg::PH_MAJOR_FIRST; else ok = 1'b0;
         end
         hrp_pkg::PH_MAJOR_FIRST: begin
            if (digit_char(c)) begin
               major_count = c - hrp_pkg::CH_ZERO; nxt = hrp_pkg::PH_MAJOR;
            end else ok = 1'b0;
         end
         hrp_pkg::PH_MAJOR: begin
            if (c == hrp_pkg::CH_DOT) nxt = hrp_pkg::PH_MINOR_FIRST;
            else if (digit_char(c)) major_count = decimal_push(major_count, c);
            else ok = 1'b0;
         end
         hrp_pkg::PH_MINOR_FIRST: begin
            if (digit_char(c)) begin
               minor_count = c - hrp_pkg::CH_ZERO; nxt = hrp_pkg::PH_MINOR;
            end else ok = 1'b0;
         end
         hrp_pkg::PH_MINOR: begin
            if (digit_char(c)) minor_count = decimal_push(minor_count, c);
            else if (c == hrp_pkg::CH_CR) begin
               r.version_ready = 1'b1;
               r.version_major = major_count;
               r.version_minor = minor_count;
               nxt = hrp_pkg::PH_LINE_LF;
            end else ok = 1'b0;
         end
         hrp_pkg::PH_LINE_LF, hrp_pkg::PH_HDR_LF: begin
            if (c == hrp_pkg::CH_LF) nxt = hrp_pkg::PH_HDR_FIRST; else ok = 1'b0;
         end
         hrp_pkg::PH_HDR_FIRST: begin
            if (c == hrp_pkg::CH_CR) nxt = hrp_pkg::PH_END_LF;
            else if (token_char(c)) begin
               r.field_kind = hrp_pkg::KIND_NAME; r.field_first = 1'b1;
               nxt = hrp_pkg::PH_HDR_NAME;
            end else ok = 1'b0;
         end
         hrp_pkg::PH_HDR_NAME: begin
            if (c == hrp_pkg::CH_COLON) nxt = hrp_pkg::PH_HDR_SP;
            else if (token_char(c)) r.field_kind = hrp_pkg::KIND_NAME;
            else ok = 1'b0;
         end
         hrp_pkg::PH_HDR_SP: begin
            if (c == hrp_pkg::CH_SP) begin
               value_started = 1'b0; nxt = hrp_pkg::PH_HDR_VALUE;
            end else ok = 1'b0;
         end
         hrp_pkg::PH_HDR_VALUE: begin
            if (c == hrp_pkg::CH_CR) begin
               if (value_started) begin
                  r.pair_end = 1'b1; value_started = 1'b0; nxt = hrp_pkg::PH_HDR_LF;
               end else ok = 1'b0;
            end else if (c > hrp_pkg::CH_CTL && c != hrp_pkg::CH_DEL) begin
               r.field_kind = hrp_pkg::KIND_VALUE;
               r.field_first = !value_started;
               value_started = 1'b1;
            end else ok = 1'b0;
         end
         hrp_pkg::PH_END_LF: begin
            if (c == hrp_pkg::CH_LF) begin
               r.status = hrp_pkg::ST_DONE;
               major_count = '0;
               minor_count = '0;
               value_started = 1'b0;
               nxt = hrp_pkg::PH_METHOD_FIRST;
            end else ok = 1'b0;
         end
         default: ok = 1'b0;
      endcase
      if (!ok) begin
         r = '0;
         r.field_kind = hrp_pkg::KIND_DELIM;
         r.out_byte = c;
         r.status = hrp_pkg::ST_ERR;
      end else begin
         parse_state = nxt;
      end
      return r;
   endfunction

   function automatic logic [7:0] random_token();
      logic [7:0] c;
      c = 8'($urandom_range(33, 126));
      while (!token_char(c)) c = 8'($urandom_range(33, 126));
      return c;
   endfunction

   task automatic add_byte(input logic [7:0] c);
      byte_stream = {byte_stream, c};
   endtask

   task automatic queue_text(input string s);
      foreach (s[i]) add_byte(s[i]);
   endtask

   // one random request head, sometimes cut short, with stray bytes mixed in
   task automatic queue_request();
      logic [7:0] msg[$];
      logic [7:0] c;
      string      proto;
      int         cut;
      proto = " HTTP/";
      repeat ($urandom_range(1, 8)) msg = {msg, random_token()};
      msg = {msg, hrp_pkg::CH_SP};
      repeat ($urandom_range(1, 12)) msg = {msg, 8'($urandom_range(33, 126))};
      foreach (proto[i]) msg = {msg, 8'(proto[i])};
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1)
         msg = {msg, 8'(hrp_pkg::CH_ZERO + $urandom_range(9))};
      msg = {msg, hrp_pkg::CH_DOT};
      repeat (($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1)
         msg = {msg, 8'(hrp_pkg::CH_ZERO + $urandom_range(9))};
      msg = {msg, hrp_pkg::CH_CR};
      msg = {msg, hrp_pkg::CH_LF};
      repeat ($urandom_range(0, 4)) begin
         repeat ($urandom_range(1, 8)) msg = {msg, random_token()};
         msg = {msg, hrp_pkg::CH_COLON};
         msg = {msg, hrp_pkg::CH_SP};
         if ($urandom_range(9) == 0) msg = {msg, hrp_pkg::CH_CR};
         repeat ($urandom_range(1, 10)) begin
            c = 8'($urandom_range(32, 255));
            while (c == hrp_pkg::CH_DEL) c = 8'($urandom_range(32, 255));
            msg = {msg, c};
         end
         msg = {msg, hrp_pkg::CH_CR};
         msg = {msg, hrp_pkg::CH_LF};
      end
      msg = {msg, hrp_pkg::CH_CR};
      msg = {msg, hrp_pkg::CH_LF};
      cut = ($urandom_range(7) == 0) ? $urandom_range(1, msg.size() - 1) : msg.size();
      for (int i = 0; i < cut; i++) begin
         if ($urandom_range(39) == 0) add_byte(8'($urandom_range(255)));
         add_byte(msg[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // driver: presents the next byte at the falling edge
   always @(negedge clock) begin : drive
      int idle_pct;
      idle_pct = (accepted_bytes < total_bytes / 3) ? 34 :
                 (accepted_bytes < 2 * total_bytes / 3) ? 48 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || accepted_bytes == offered_bytes) begin
         if (byte_stream.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_tdata <= byte_stream.pop_front();
            req_tvalid <= 1'b1;
            offered_bytes++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off once stalls stop
   always @(negedge clock) begin : accept
      int idle_pct;
      idle_pct = (results_seen < total_bytes / 3) ? 48 :
                 (results_seen < 2 * total_bytes / 3) ? 34 : 0;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 2 * total_bytes / 3 + 200) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // monitor: predicts on input accept, checks on result accept
   always @(posedge clock) begin : watch
      hrp_pkg::result_type want;
      hrp_pkg::result_type tag;
      if (reset) begin
         parse_state = hrp_pkg::PH_METHOD_FIRST;
         major_count = '0;
         minor_count = '0;
         value_started = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tag = tag_byte(req_tdata);
            expected_tags = {expected_tags, tag};
            accepted_bytes++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_tags.size() == 0) begin
               $error("result item 0x%0h with no byte pending", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_tags.pop_front();
               check_field("out_byte", 32'(want.out_byte), 32'(rsp_tdata[7:0]));
               check_field("pair_end", 32'(want.pair_end), 32'(rsp_tdata[8]));
               check_field("version_ready", 32'(want.version_ready), 32'(rsp_tdata[9]));
               check_field("version_major", 32'(want.version_major),
                           32'(rsp_tdata[17:10]));
               check_field("version_minor", 32'(want.version_minor),
                           32'(rsp_tdata[25:18]));
               check_field("status", 32'(want.status), 32'(rsp_tdata[27:26]));
               check_field("field_kind", 32'(want.field_kind), 32'(rsp_tuser[2:0]));
               check_field("field_first", 32'(want.field_first), 32'(rsp_tuser[3]));
               check_field("padding", 32'd0, 32'({rsp_tdata[31:28], rsp_tuser[7:4]}));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;

      // directed: bad first byte, CR in uri, saturating versions,
      // empty header value, top byte as value, empty line
      add_byte(8'h00);
      queue_text("G /");
      add_byte(hrp_pkg::CH_CR);
      queue_text(" HTTP/999.256");
      add_byte(hrp_pkg::CH_CR);
      add_byte(hrp_pkg::CH_LF);
      queue_text("A: ");
      add_byte(hrp_pkg::CH_CR);
      add_byte(8'hFF);
      add_byte(hrp_pkg::CH_CR);
      add_byte(hrp_pkg::CH_LF);
      add_byte(hrp_pkg::CH_CR);
      add_byte(hrp_pkg::CH_LF);

      while (byte_stream.size() < 1700) queue_request();
      total_bytes = byte_stream.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(byte_stream.size() == 0 && accepted_bytes == offered_bytes &&
               expected_tags.size() == 0))
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
src/hrp_pkg.sv
src/hrp_input_reg.sv
src/hrp_parser.sv
src/hrp_output_reg.sv
src/http_request_head_parser_top.sv
test/http_request_head_parser_top_test.sv
